### hw/rtl/sir_pkg.sv
// shared types and constants for the sir midpoint step core
package sir_pkg;

    localparam int unsigned PW = 48;
    localparam logic [PW-1:0] MAXV = 48'hFFFF_FFFF_FFFF;
    localparam logic [PW-1:0] ONE = 48'd65536;

    // input opcodes
    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_STEP  = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    // configuration register indexes
    localparam logic [2:0] REG_TAU    = 3'd0;
    localparam logic [2:0] REG_PERIOD = 3'd1;
    localparam logic [2:0] REG_COUNT  = 3'd2;
    localparam logic [2:0] REG_INIT_S = 3'd3;
    localparam logic [2:0] REG_INIT_I = 3'd4;
    localparam logic [2:0] REG_INIT_R = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIVCHK,
        ST_DIV,
        ST_WB,
        ST_RATE,
        ST_UPD,
        ST_OUT
    } t_state;

    // micro operations of one step
    typedef enum logic [2:0] {
        U_KDAY,
        U_REC,
        U_X,
        U_INF,
        U_A,
        U_B
    } t_uop;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [47:0] sample_time;
        logic [5:0]  entry_index;
        logic [23:0] entry_rate;
    } t_in_item;

    typedef struct packed {
        logic [47:0] susceptible;
        logic [47:0] infected;
        logic [47:0] removed;
        logic        status;
    } t_out_item;

    typedef struct packed {
        logic [2:0]  index;
        logic [47:0] data;
    } t_cfg_wr;

endpackage

### hw/rtl/sir_if.sv
// handshake channels for input items, results and configuration writes
interface sir_in_if import sir_pkg::*;;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sir_out_if import sir_pkg::*;;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sir_cfg_if import sir_pkg::*;;
    logic    valid;
    logic    ready;
    t_cfg_wr data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/sir_epidemic_midpoint_step_core.sv
// sir epidemic integrator, one explicit midpoint step per step word
//
// channels: i_in takes words (load rate entry, start run, advance step),
// o_res gives one result word for each start and step word, i_cfg writes
// the six configuration registers and is ready whenever reset is released.
// a load or unused word gives no result. a start word, or a step on a zero
// population, raises o_res.valid in the cycle after acceptance.
// a step word runs on one shared unit: a 48x16 multiplier that builds each
// product from 16-bit slices of its second operand, then either a shift
// with writeback or a restoring divider that makes two quotient bits a
// cycle, with check and writeback. a step needs one day-index division,
// four quotients by tau or by the total population and six shifts. the
// next word is taken only after the result leaves o_res.
// i_in is ready only when idle and out of reset.
// the result sits in the output register until o_res is taken; a stalled
// receiver holds the core blocked, no word is lost.
// reset clears the populations, times and registers to their defaults;
// the rate table holds no reset value and needs no clearing pass.
module sir_epidemic_midpoint_step_core import sir_pkg::*; #(
    parameter int RATE_TABLE_DEPTH = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sir_in_if.sink    i_in,
    sir_out_if.source o_res,
    sir_cfg_if.sink   i_cfg
);

    localparam int IW = (RATE_TABLE_DEPTH > 1) ? $clog2(RATE_TABLE_DEPTH) : 1;

    // configuration registers
    logic [31:0] r_tau;
    logic [15:0] r_period;
    logic [6:0]  r_count;
    logic [47:0] r_init_s, r_init_i, r_init_r;

    // population and time state
    logic [47:0] r_s, r_i, r_r, r_prev, r_start, r_t;
    logic        r_status;

    // step working registers
    logic [47:0] r_cs, r_ci, r_rec, r_x, r_inf, r_a, r_mag, r_q, r_dq;
    logic [49:0] r_n, r_rem;
    logic [23:0] r_rt;
    logic        r_neg, r_pass;
    logic [95:0] r_acc;
    logic [1:0]  r_mcnt;
    logic [4:0]  r_dcnt;
    t_state      r_state, n_state;
    t_uop        r_op;

    logic [23:0] rate_mem [RATE_TABLE_DEPTH];

    assign i_cfg.ready = i_rst_n;
    assign i_in.ready  = i_rst_n && (r_state == ST_IDLE);
    assign o_res.valid = (r_state == ST_OUT);
    assign o_res.data.susceptible = r_s;
    assign o_res.data.infected    = r_i;
    assign o_res.data.removed     = r_r;
    assign o_res.data.status      = r_status;

    logic in_acc;
    assign in_acc = i_in.valid && i_in.ready;

    // operand selection for the shared unit
    logic [47:0] op_a, op_b, cur_s, cur_i, dday;
    logic [49:0] op_c;
    logic        op_shift;
    logic [4:0]  op_sh;
    logic [31:0] tau_eff;
    logic [15:0] per_eff;

    always_comb begin
        tau_eff = (r_tau == 32'd0) ? 32'd1 : r_tau;
        per_eff = (r_period == 16'd0) ? 16'd1 : r_period;
        cur_s = r_pass ? r_cs : r_s;
        cur_i = r_pass ? r_ci : r_i;
        dday = (r_prev >= r_start) ? {16'd0, 32'((r_prev - r_start) >> 16)} : 48'd0;
        op_a = 48'd0;
        op_b = 48'd0;
        op_c = 50'd1;
        op_shift = 1'b0;
        op_sh = r_pass ? 5'd16 : 5'd17;
        case (r_op)
            U_KDAY: begin
                op_a = dday;
                op_b = 48'd1;
                op_c = {34'd0, per_eff};
            end
            U_REC: begin
                op_a = cur_i;
                op_b = ONE;
                op_c = {18'd0, tau_eff};
            end
            U_X: begin
                op_a = r_rec;
                op_b = cur_s;
                op_c = r_n;
            end
            U_INF: begin
                op_a = r_x;
                op_b = {24'd0, r_rt};
                op_shift = 1'b1;
                op_sh = 5'd16;
            end
            U_A: begin
                op_a = r_mag;
                op_b = r_inf;
                op_shift = 1'b1;
            end
            U_B: begin
                op_a = r_mag;
                op_b = r_rec;
                op_shift = 1'b1;
            end
            default: begin
                op_a = 48'd0;
            end
        endcase
    end

    // multiplier slice and accumulate
    logic [15:0] b_slice;
    logic [63:0] pp;
    logic [95:0] acc_next;

    always_comb begin
        case (r_mcnt)
            2'd0:    b_slice = op_b[15:0];
            2'd1:    b_slice = op_b[31:16];
            default: b_slice = op_b[47:32];
        endcase
        pp = op_a * b_slice;
        case (r_mcnt)
            2'd0:    acc_next = {32'd0, pp};
            2'd1:    acc_next = r_acc + ({32'd0, pp} << 16);
            default: acc_next = r_acc + ({32'd0, pp} << 32);
        endcase
    end

    // shift path and divider steps
    logic [95:0] sh_q;
    logic [49:0] rem_n;
    logic [47:0] dq_n;
    logic [50:0] trial;
    logic        ge;

    always_comb begin
        sh_q = r_acc >> op_sh;
        rem_n = r_rem;
        dq_n = r_dq;
        trial = 51'd0;
        ge = 1'b0;
        for (int k = 0; k < 2; k++) begin
            trial = {rem_n, dq_n[47]};
            ge = (trial >= {1'b0, op_c});
            rem_n = ge ? 50'(trial - {1'b0, op_c}) : trial[49:0];
            dq_n = {dq_n[46:0], ge};
        end
    end

    // rate index clamp
    logic [47:0] cnt_eff, k_cl;
    always_comb begin
        if (r_count == 7'd0) begin
            cnt_eff = 48'd1;
        end else if (32'(r_count) > RATE_TABLE_DEPTH) begin
            cnt_eff = 48'(RATE_TABLE_DEPTH);
        end else begin
            cnt_eff = {41'd0, r_count};
        end
        k_cl = (r_q >= cnt_eff) ? cnt_eff - 48'd1 : r_q;
    end

    // population update with sign and saturation
    logic signed [50:0] da, db, vs, vi, vr;
    logic [47:0] ns, ni, nr;

    function automatic logic [47:0] clamp_pop(input logic signed [50:0] v);
        if (v < 0) begin
            return 48'd0;
        end else if (v > $signed({3'd0, MAXV})) begin
            return MAXV;
        end
        return v[47:0];
    endfunction

    always_comb begin
        da = $signed({3'd0, r_a});
        db = $signed({3'd0, r_q});
        if (r_neg) begin
            vs = $signed({3'd0, r_s}) + da;
            vi = $signed({3'd0, r_i}) - da + db;
            vr = $signed({3'd0, r_r}) - db;
        end else begin
            vs = $signed({3'd0, r_s}) - da;
            vi = $signed({3'd0, r_i}) + da - db;
            vr = $signed({3'd0, r_r}) + db;
        end
        ns = clamp_pop(vs);
        ni = clamp_pop(vi);
        nr = clamp_pop(vr);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in.data.opcode == OP_START) begin
                        n_state = ST_OUT;
                    end else if (i_in.data.opcode == OP_STEP) begin
                        n_state = (~|{r_s, r_i, r_r}) ? ST_OUT : ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                if (r_mcnt == 2'd2) begin
                    n_state = ST_DIVCHK;
                end
            end
            ST_DIVCHK: begin
                if (op_shift || (r_acc[95:48] >= op_c)) begin
                    n_state = ST_WB;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_dcnt == 5'd23) begin
                    n_state = ST_WB;
                end
            end
            ST_WB: begin
                case (r_op)
                    U_KDAY:  n_state = ST_RATE;
                    U_B:     n_state = ST_UPD;
                    default: n_state = ST_MUL;
                endcase
            end
            ST_RATE: n_state = ST_MUL;
            ST_UPD:  n_state = r_pass ? ST_OUT : ST_MUL;
            ST_OUT: begin
                if (o_res.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tau <= 32'd655360;
            r_period <= 16'd7;
            r_count <= 7'd1;
            r_init_s <= 48'd0;
            r_init_i <= 48'd0;
            r_init_r <= 48'd0;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                REG_TAU:    r_tau <= i_cfg.data.data[31:0];
                REG_PERIOD: r_period <= i_cfg.data.data[15:0];
                REG_COUNT:  r_count <= i_cfg.data.data[6:0];
                REG_INIT_S: r_init_s <= i_cfg.data.data;
                REG_INIT_I: r_init_i <= i_cfg.data.data;
                REG_INIT_R: r_init_r <= i_cfg.data.data;
                default: begin
                end
            endcase
        end
    end

    // rate table
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_in.data.opcode == OP_LOAD)
                && (32'(i_in.data.entry_index) < RATE_TABLE_DEPTH)) begin
            rate_mem[IW'(i_in.data.entry_index)] <= i_in.data.entry_rate;
        end
        if (r_state == ST_RATE) begin
            r_rt <= rate_mem[k_cl[IW-1:0]];
        end
    end

    // population state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s <= 48'd0;
            r_i <= 48'd0;
            r_r <= 48'd0;
            r_prev <= 48'd0;
            r_start <= 48'd0;
            r_status <= 1'b0;
        end else if (in_acc && (i_in.data.opcode == OP_START)) begin
            r_start <= i_in.data.sample_time;
            r_prev <= i_in.data.sample_time;
            r_s <= r_init_s;
            r_i <= r_init_i;
            r_r <= r_init_r;
            r_status <= 1'b0;
        end else if (in_acc && (i_in.data.opcode == OP_STEP)) begin
            r_status <= (n_state == ST_OUT);
            if (n_state == ST_OUT) begin
                r_prev <= i_in.data.sample_time;
            end
        end else if ((r_state == ST_UPD) && r_pass) begin
            r_s <= ns;
            r_i <= ni;
            r_r <= nr;
            r_prev <= r_t;
        end
    end

    // step datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= U_KDAY;
            r_pass <= 1'b0;
            r_mcnt <= 2'd0;
            r_dcnt <= 5'd0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    r_op <= U_KDAY;
                    r_pass <= 1'b0;
                    r_mcnt <= 2'd0;
                    r_t <= i_in.data.sample_time;
                    r_n <= {2'd0, r_s} + {2'd0, r_i} + {2'd0, r_r};
                    r_neg <= (i_in.data.sample_time < r_prev);
                    r_mag <= (i_in.data.sample_time < r_prev)
                        ? r_prev - i_in.data.sample_time
                        : i_in.data.sample_time - r_prev;
                end
                ST_MUL: begin
                    r_acc <= acc_next;
                    r_mcnt <= (r_mcnt == 2'd2) ? 2'd0 : r_mcnt + 2'd1;
                end
                ST_DIVCHK: begin
                    r_dcnt <= 5'd0;
                    if (op_shift) begin
                        r_q <= (|sh_q[95:48]) ? MAXV : sh_q[47:0];
                    end else if (r_acc[95:48] >= op_c) begin
                        r_q <= MAXV;
                    end else begin
                        r_rem <= {2'd0, r_acc[95:48]};
                        r_dq <= r_acc[47:0];
                    end
                end
                ST_DIV: begin
                    r_rem <= rem_n;
                    r_dq <= dq_n;
                    r_dcnt <= r_dcnt + 5'd1;
                    if (r_dcnt == 5'd23) begin
                        r_q <= dq_n;
                    end
                end
                ST_WB: begin
                    case (r_op)
                        U_REC: begin
                            r_rec <= r_q;
                            r_op <= U_X;
                        end
                        U_X: begin
                            r_x <= r_q;
                            r_op <= U_INF;
                        end
                        U_INF: begin
                            r_inf <= r_q;
                            r_op <= U_A;
                        end
                        U_A: begin
                            r_a <= r_q;
                            r_op <= U_B;
                        end
                        default: begin
                        end
                    endcase
                end
                ST_RATE: r_op <= U_REC;
                ST_UPD: begin
                    r_cs <= ns;
                    r_ci <= ni;
                    r_pass <= 1'b1;
                    r_op <= U_REC;
                end
                default: begin
                end
            endcase
        end
    end

endmodule
